// ===== src/bibm_pkg.sv =====
package bibm_pkg;

	localparam int COL_W = 13;
	localparam int ROW_W = 12;
	localparam int CMP_W = 14;
	localparam int DEF_MAX_WIDTH = 1024;

	localparam logic [10:0] RST_FRAME_WIDTH = 11'd800;
	localparam logic [11:0] RST_FRAME_HEIGHT = 12'd600;

	localparam logic [0:0] REG_FRAME_WIDTH = 1'b0;
	localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

	localparam logic [1:0] LBL_OUT = 2'd0;
	localparam logic [1:0] LBL_INT = 2'd1;
	localparam logic [1:0] LBL_BND = 2'd2;

	// one accepted pixel and the results it releases
	typedef struct packed {
		logic [2:0] pend;
		logic [1:0] lab0;
		logic up1;
		logic bit_in;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
	} bibm_item_t;

endpackage

// ===== src/binary_inner_boundary_marker_core.sv =====
// binary inner boundary marker: 3x3 erosion test on a raster bitmap
// s_axis carries one membership bit per request in raster order (tdata[0], 1 inside);
// frame_width and frame_height set the raster geometry through the cfg write port
// (index 0 width, index 1 height), written only while the block is idle: the user
// must ensure this, as the block does not enforce it. m_axis returns labels: 0 outside,
// 1 interior, 2 boundary; edge rows and columns keep the input bit. each result carries
// its column and row, and tlast marks the final result caused by one input pixel.
// labels trail the input by one row and one column; the last column and the last
// row are released as soon as their pixel arrives, so one input gives 0 to 3 results.
// a result goes from the staged-pixel register into the output register driving m_axis.
// throughput: one pixel per cycle while each pixel releases at most one result and
// m_axis_tready is high; a pixel releasing more results holds the input until its
// last one moves into the single output register, which takes one result per cycle.
// the line stores are one memory read a column ahead and written once per pixel.
// reset clears counters, window and handshake state; line stores hold no reset.
// when m_axis_tready is low the output holds, then the staged pixel, then s_axis stalls.
module binary_inner_boundary_marker_core #(
	parameter int MAX_WIDTH = bibm_pkg::DEF_MAX_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [0] in_set, [7:1] zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [9:0] pix_col, [21:10] pix_row, [23:22] label
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	logic [10:0] frame_width_q;
	logic [11:0] frame_height_q;
	bibm_pkg::bibm_item_t item;
	logic [9:0]  pix_col;
	logic [11:0] pix_row;
	logic [1:0]  label;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= bibm_pkg::RST_FRAME_WIDTH;
			frame_height_q <= bibm_pkg::RST_FRAME_HEIGHT;
		end else if (cfg_we) begin
			case (cfg_index)
				bibm_pkg::REG_FRAME_WIDTH: frame_width_q <= cfg_data[10:0];
				bibm_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	bibm_scan #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_set       (s_axis_tdata[0]),
		.item         (item)
	);

	bibm_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.item      (item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_col   (pix_col),
		.out_row   (pix_row),
		.out_label (label),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {label, pix_row, pix_col};

endmodule

// ===== src/bibm_line_store.sv =====
module bibm_line_store #(
	parameter int DEPTH = bibm_pkg::DEF_MAX_WIDTH,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [1:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [1:0]    rdata
);

	// bit 0 is the previous row, bit 1 the row before it
	logic [1:0] mem [DEPTH];
	logic [1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/bibm_scan.sv =====
module bibm_scan #(
	parameter int MAX_WIDTH = bibm_pkg::DEF_MAX_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [10:0]              frame_width,
	input  logic [11:0]              frame_height,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic                     in_set,
	output bibm_pkg::bibm_item_t     item
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = bibm_pkg::ROW_W;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [8:0]    win_q;
	logic [CW-1:0] col_d;
	logic [RW-1:0] row_d;
	logic [8:0]    win_d;
	logic [CW-1:0] wl;
	logic [RW-1:0] hl;
	logic [1:0]    rd;
	logic          acc;
	logic          up1;
	logic          up2;
	logic          c_last;
	logic          r_last;
	logic          edge0;
	logic          center;
	logic [bibm_pkg::CMP_W-1:0] w_ext;

	assign acc = in_valid && in_ready;

	// effective last column and last row
	always_comb begin
		w_ext = bibm_pkg::CMP_W'(frame_width);
		if (w_ext < bibm_pkg::CMP_W'(3)) begin
			wl = CW'(2);
		end else if (w_ext > bibm_pkg::CMP_W'(MAX_WIDTH)) begin
			wl = CW'(MAX_WIDTH - 1);
		end else begin
			wl = CW'(w_ext - bibm_pkg::CMP_W'(1));
		end
		if (frame_height < RW'(3)) begin
			hl = RW'(2);
		end else begin
			hl = frame_height - RW'(1);
		end
	end

	assign up1 = (row_q != '0) ? rd[0] : 1'b0;
	assign up2 = (row_q >= RW'(2)) ? rd[1] : 1'b0;
	assign win_d = {win_q[5:0], in_set, up1, up2};
	assign center = win_d[4];

	assign c_last = col_q >= wl;
	assign r_last = row_q >= hl;
	assign edge0 = (col_q == CW'(1)) || (row_q == RW'(1)) || (col_q > wl) || (row_q > hl);

	always_comb begin
		if (c_last) begin
			col_d = '0;
			row_d = r_last ? '0 : row_q + RW'(1);
		end else begin
			col_d = col_q + CW'(1);
			row_d = row_q;
		end
	end

	always_comb begin
		item.pend[0] = (row_q != '0) && (col_q != '0);
		item.pend[1] = (row_q != '0) && c_last;
		item.pend[2] = r_last;
		if (edge0) begin
			item.lab0 = {1'b0, center};
		end else if (!center) begin
			item.lab0 = bibm_pkg::LBL_OUT;
		end else if (win_d == 9'h1FF) begin
			item.lab0 = bibm_pkg::LBL_INT;
		end else begin
			item.lab0 = bibm_pkg::LBL_BND;
		end
		item.up1 = up1;
		item.bit_in = in_set;
		item.col = bibm_pkg::COL_W'(col_q);
		item.row = row_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			win_q <= '0;
		end else if (acc) begin
			col_q <= col_d;
			row_q <= row_d;
			win_q <= win_d;
		end
	end

	// read one column ahead so the entry is ready when its pixel arrives
	bibm_line_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line (
		.clk   (clk),
		.we    (acc),
		.waddr (col_q),
		.wdata ({up1, in_set}),
		.raddr (acc ? col_d : col_q),
		.rdata (rd)
	);

endmodule

// ===== src/bibm_emit.sv =====
module bibm_emit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  bibm_pkg::bibm_item_t  item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [9:0]            out_col,
	output logic [11:0]           out_row,
	output logic [1:0]            out_label,
	output logic                  out_last
);

	localparam int CLW = bibm_pkg::COL_W;
	localparam int RW = bibm_pkg::ROW_W;

	logic [2:0]     pend_s1;
	logic [1:0]     lab0_s1;
	logic           up1_s1;
	logic           bit_s1;
	logic [CLW-1:0] col_s1;
	logic [RW-1:0]  row_s1;

	logic           out_valid_q;
	logic [9:0]     col_q;
	logic [11:0]    row_q;
	logic [1:0]     label_q;
	logic           last_q;

	logic           out_free;
	logic           load;
	logic [2:0]     pend_left;
	logic [CLW-1:0] sel_col;
	logic [RW-1:0]  sel_row;
	logic [1:0]     sel_label;

	assign out_free = !out_valid_q || out_ready;
	assign load = out_free && (pend_s1 != '0);
	// drop the lowest pending result
	assign pend_left = pend_s1 & (pend_s1 - 3'd1);
	assign in_ready = (pend_s1 == '0) || (load && (pend_left == '0));

	always_comb begin
		if (pend_s1[0]) begin
			sel_col = col_s1 - CLW'(1);
			sel_row = row_s1 - RW'(1);
			sel_label = lab0_s1;
		end else if (pend_s1[1]) begin
			sel_col = col_s1;
			sel_row = row_s1 - RW'(1);
			sel_label = {1'b0, up1_s1};
		end else begin
			sel_col = col_s1;
			sel_row = row_s1;
			sel_label = {1'b0, bit_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				pend_s1 <= item.pend;
			end else if (load) begin
				pend_s1 <= pend_left;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			lab0_s1 <= item.lab0;
			up1_s1 <= item.up1;
			bit_s1 <= item.bit_in;
			col_s1 <= item.col;
			row_s1 <= item.row;
		end
		if (load) begin
			col_q <= sel_col[9:0];
			row_q <= sel_row;
			label_q <= sel_label;
			last_q <= (pend_left == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign out_col = col_q;
	assign out_row = row_q;
	assign out_label = label_q;
	assign out_last = last_q;

	// a new pixel may only enter when its predecessor's results are leaving
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && pend_s1 != '0) |-> (out_free && $onehot(pend_s1)))
		else $error("pending results overwritten");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_s1 != '0 && out_free) |=> out_valid_q)
		else $error("pending result not moved to output");

	a_label: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (label_q != 2'd3))
		else $error("invalid label code");

endmodule
